>>> rtl/bnv_pkg.sv
`timescale 1ns / 1ps

package bnv_pkg;

   // Geometry defaults
   localparam int unsigned DEFAULT_MAX_DIMENSION = 4096;

   // Configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 13;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Fixed-point colour coefficients (scaled by 256)
   localparam int unsigned SUM_WIDTH = 18;

   localparam logic signed [SUM_WIDTH-1:0] Y_COEF_R = 18'sd76;
   localparam logic signed [SUM_WIDTH-1:0] Y_COEF_G = 18'sd150;
   localparam logic signed [SUM_WIDTH-1:0] Y_COEF_B = 18'sd29;

   localparam logic signed [SUM_WIDTH-1:0] U_COEF_R = -18'sd43;
   localparam logic signed [SUM_WIDTH-1:0] U_COEF_G = -18'sd84;
   localparam logic signed [SUM_WIDTH-1:0] U_COEF_B = 18'sd127;

   localparam logic signed [SUM_WIDTH-1:0] V_COEF_R = 18'sd127;
   localparam logic signed [SUM_WIDTH-1:0] V_COEF_G = -18'sd106;
   localparam logic signed [SUM_WIDTH-1:0] V_COEF_B = -18'sd21;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_TERM = 18'sd128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic chroma_valid;
      logic frame_last;
   } position_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       frame_last;
   } result_type;

endpackage

>>> rtl/bgr_to_nv12_converter_unit.sv
`timescale 1ns / 1ps

// Channel   Ports            Payload
// ------    ---------------  --------------------------------------------------
// input     req_t*           tdata: blue, green, red (8 bits each)
// result    rsp_t*           tdata: luma, chroma_u, chroma_v; tuser: chroma_valid;
//                            tlast: frame_last
// config    csr_*            index 0 frame_width, index 1 frame_height (13 bits)
//
// One item per cycle while the result side takes them; each item passes through
// the input register and then the result register, with the colour sums in
// between. Synchronous reset clears both stage valids and the raster counters,
// and loads 640 by 480 into the frame registers. A result-side stall holds
// the result register, then the input; req_tready falls only when both are full.

module bgr_to_nv12_converter_unit
   import bnv_pkg::*;
#(
   parameter int unsigned MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // blue, green, red
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // luma, chroma_u, chroma_v
   output logic                       rsp_tuser,  // chroma_valid
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   pixel_type    pixel_ff, pixel_in;
   position_type position_ff, position_in;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   result_ff, result_in;
   result_type   result_c;
   position_type position_c;
   logic         req_accept, stage_advance, out_free;

   // Handshake: each register takes a new item once its own is gone
   assign out_free      = ~rsp_valid_ff | rsp_tready;
   assign stage_advance = in_valid_ff & out_free;
   assign req_tready    = ~in_valid_ff | out_free;
   assign req_accept    = req_tvalid & req_tready;

   bnv_position_tracker #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_accept),
      .position  (position_c)
   );

   bnv_colour_math u_math (
      .pixel    (pixel_ff),
      .position (position_ff),
      .result   (result_c)
   );

   // Load the input register on accept, drain it into the result register
   always_comb begin
      pixel_in     = pixel_ff;
      position_in  = position_ff;
      in_valid_in  = in_valid_ff & ~stage_advance;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (req_accept) begin
         pixel_in.blue  = req_tdata[7:0];
         pixel_in.green = req_tdata[15:8];
         pixel_in.red   = req_tdata[23:16];
         position_in    = position_c;
         in_valid_in    = 1'b1;
      end
      if (stage_advance) begin
         result_in    = result_c;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff    <= pixel_in;
      position_ff <= position_in;
      result_ff   <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {result_ff.chroma_v, result_ff.chroma_u, result_ff.luma};
   assign rsp_tuser  = result_ff.chroma_valid;
   assign rsp_tlast  = result_ff.frame_last;

endmodule

>>> rtl/bnv_position_tracker.sv
`timescale 1ns / 1ps

module bnv_position_tracker
   import bnv_pkg::*;
#(
   parameter int unsigned MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       advance,
   output position_type               position
);

   localparam int unsigned CW = $clog2(MAX_DIMENSION);
   localparam int unsigned DW = CW + 1;
   localparam logic [CSR_DATA_WIDTH:0] MAX_DIM_EXT = (CSR_DATA_WIDTH+1)'(MAX_DIMENSION);

   logic [CSR_DATA_WIDTH-1:0] frame_width_ff, frame_width_in;
   logic [CSR_DATA_WIDTH-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0]             column_ff, column_in;
   logic [CW-1:0]             row_ff, row_in;
   logic [DW-1:0]             width_c, height_c;
   logic [DW-1:0]             column_plus, row_plus;
   logic                      end_row, end_frame;

   // Zero counts as one, anything above the maximum saturates
   function automatic logic [DW-1:0] clamp_dim(input logic [CSR_DATA_WIDTH-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if ({1'b0, v} > MAX_DIM_EXT) begin
         r = DW'(MAX_DIM_EXT);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   // Take register writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Find row and frame ends at the current position
   always_comb begin
      width_c     = clamp_dim(frame_width_ff);
      height_c    = clamp_dim(frame_height_ff);
      column_plus = {1'b0, column_ff} + DW'(1);
      row_plus    = {1'b0, row_ff} + DW'(1);
      end_row     = column_plus >= width_c;
      end_frame   = end_row && (row_plus >= height_c);
   end

   // Advance the raster position on each accepted item
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (end_frame) begin
            column_in = '0;
            row_in    = '0;
         end else if (end_row) begin
            column_in = '0;
            row_in    = row_plus[CW-1:0];
         end else begin
            column_in = column_plus[CW-1:0];
         end
      end
   end

   assign position.chroma_valid = row_ff[0] & ~column_ff[0];
   assign position.frame_last   = end_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         column_ff       <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
      end
   end

endmodule

>>> rtl/bnv_colour_math.sv
`timescale 1ns / 1ps

module bnv_colour_math
   import bnv_pkg::*;
(
   input  pixel_type    pixel,
   input  position_type position,
   output result_type   result
);

   logic signed [SUM_WIDTH-1:0] r_s, g_s, b_s;
   logic signed [SUM_WIDTH-1:0] y_sum, u_sum, v_sum;
   logic signed [SUM_WIDTH-1:0] u_shift, v_shift;

   // Widen the components to signed operands
   always_comb begin
      r_s = signed'({{(SUM_WIDTH-8){1'b0}}, pixel.red});
      g_s = signed'({{(SUM_WIDTH-8){1'b0}}, pixel.green});
      b_s = signed'({{(SUM_WIDTH-8){1'b0}}, pixel.blue});
   end

   // Form the rounded weighted sums
   always_comb begin
      y_sum   = Y_COEF_R * r_s + Y_COEF_G * g_s + Y_COEF_B * b_s + ROUND_TERM;
      u_sum   = U_COEF_R * r_s + U_COEF_G * g_s + U_COEF_B * b_s + ROUND_TERM;
      v_sum   = V_COEF_R * r_s + V_COEF_G * g_s + V_COEF_B * b_s + ROUND_TERM;
      u_shift = u_sum >>> 8;
      v_shift = v_sum >>> 8;
   end

   // Offset chroma by 128 (flip of the top bit), drop it off chroma sites
   always_comb begin
      result.luma         = y_sum[15:8];
      result.chroma_valid = position.chroma_valid;
      result.frame_last   = position.frame_last;
      if (position.chroma_valid) begin
         result.chroma_u = {~u_shift[7], u_shift[6:0]};
         result.chroma_v = {~v_shift[7], v_shift[6:0]};
      end else begin
         result.chroma_u = '0;
         result.chroma_v = '0;
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
   import bnv_pkg::*;
();

   localparam int unsigned MAX_DIM        = DEFAULT_MAX_DIMENSION;
   localparam int unsigned STALL_LIMIT    = 2000;
   localparam int unsigned HOLD_OFF_LEN   = 80;
   localparam int unsigned PIPE_SETTLE    = 4;
   localparam int unsigned MAX_REPORTS    = 10;

   // Colour conversion and raster tracking, plus the queue of pixels still owed
   class nv12_scoreboard;
      int unsigned frame_width;
      int unsigned frame_height;
      int unsigned column_count;
      int unsigned row_count;
      int unsigned mismatch_count;
      result_type  expected_pixels[$];

      function new();
         frame_width    = 32'(FRAME_WIDTH_RESET);
         frame_height   = 32'(FRAME_HEIGHT_RESET);
         column_count   = 0;
         row_count      = 0;
         mismatch_count = 0;
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_WIDTH-1:0] value);
         if (index == CSR_FRAME_WIDTH) begin
            frame_width = 32'(value);
         end else begin
            frame_height = 32'(value);
         end
      endfunction

      // Zero counts as one, anything beyond the maximum saturates
      function int unsigned limit_dimension(int unsigned value);
         if (value == 0) begin
            return 1;
         end
         if (value > MAX_DIM) begin
            return MAX_DIM;
         end
         return value;
      endfunction

      // Convert one accepted pixel and advance the raster position
      function void note_pixel(logic [23:0] tdata);
         int          blue;
         int          green;
         int          red;
         int          luma_sum;
         int          u_sum;
         int          v_sum;
         int unsigned width_eff;
         int unsigned height_eff;
         bit          end_row;
         result_type  pixel_out;
         blue       = 32'(tdata[7:0]);
         green      = 32'(tdata[15:8]);
         red        = 32'(tdata[23:16]);
         width_eff  = limit_dimension(frame_width);
         height_eff = limit_dimension(frame_height);
         luma_sum   = 76 * red + 150 * green + 29 * blue + 128;
         u_sum      = -43 * red - 84 * green + 127 * blue + 128;
         v_sum      = 127 * red - 106 * green - 21 * blue + 128;
         end_row    = (column_count + 1 >= width_eff);

         pixel_out.luma         = 8'(luma_sum >>> 8);
         pixel_out.chroma_valid = row_count[0] && !column_count[0];
         pixel_out.chroma_u     = pixel_out.chroma_valid ? 8'((u_sum >>> 8) + 128) : 8'd0;
         pixel_out.chroma_v     = pixel_out.chroma_valid ? 8'((v_sum >>> 8) + 128) : 8'd0;
         pixel_out.frame_last   = end_row && (row_count + 1 >= height_eff);
         expected_pixels.push_back(pixel_out);

         if (pixel_out.frame_last) begin
            column_count = 0;
            row_count    = 0;
         end else if (end_row) begin
            column_count = 0;
            row_count    = row_count + 1;
         end else begin
            column_count = column_count + 1;
         end
      endfunction

      // Compare one accepted result with the oldest pixel owed
      function void check_result(logic [23:0] tdata, logic tuser, logic tlast);
         result_type pixel_exp;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result: luma %0d u %0d v %0d chroma %0b last %0b",
                        tdata[7:0], tdata[15:8], tdata[23:16], tuser, tlast);
            end
            return;
         end
         pixel_exp = expected_pixels.pop_front();
         if (tdata[7:0] !== pixel_exp.luma || tdata[15:8] !== pixel_exp.chroma_u ||
             tdata[23:16] !== pixel_exp.chroma_v || tuser !== pixel_exp.chroma_valid ||
             tlast !== pixel_exp.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("result mismatch: expected luma %0d u %0d v %0d chroma %0b last %0b",
                        pixel_exp.luma, pixel_exp.chroma_u, pixel_exp.chroma_v,
                        pixel_exp.chroma_valid, pixel_exp.frame_last);
               $display("                 actual   luma %0d u %0d v %0d chroma %0b last %0b",
                        tdata[7:0], tdata[15:8], tdata[23:16], tuser, tlast);
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [23:0]                req_tdata;   // blue, green, red
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [23:0]                rsp_tdata;   // luma, chroma_u, chroma_v
   logic                       rsp_tuser;   // chroma_valid
   logic                       rsp_tlast;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   nv12_scoreboard sb;
   int unsigned    stall_cycles = 0;
   int unsigned    pixels_sent  = 0;
   int unsigned    pixels_taken = 0;
   bit             sender_idles = 1;
   bit             sink_idles   = 1;
   bit             burst_mode   = 0;
   bit             handshake_seen;

   bgr_to_nv12_converter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Extremes as {red, green, blue}
   function automatic logic [23:0] corner_pixel(int k);
      case (k)
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'hFF0000;
         3: return 24'h00FF00;
         4: return 24'h0000FF;
         5: return 24'h00FFFF;
         6: return 24'hFFFF00;
         7: return 24'hFF00FF;
         8: return 24'h7F8001;
         default: return 24'hAA55C3;
      endcase
   endfunction

   // Bias each component towards the rails now and then
   function automatic logic [7:0] draw_component();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one pixel and hold it until the block takes it
   task automatic send_pixel(input logic [23:0] pixel);
      int unsigned gap;
      if (pixels_sent % 40 == 0) begin
         sender_idles = ($urandom_range(0, 2) != 0);
      end
      gap = (sender_idles && !burst_mode) ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // Drop valid, wait for every owed pixel, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_register(index, value);
   endtask

   task automatic run_frames(input logic [CSR_DATA_WIDTH-1:0] width,
                             input logic [CSR_DATA_WIDTH-1:0] height, input int count);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, width);
      write_csr(CSR_FRAME_HEIGHT, height);
      repeat (count) send_pixel({draw_component(), draw_component(), draw_component()});
   endtask

   // Stimulus
   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A few pixels at the reset geometry
      for (int k = 0; k < 5; k++) begin
         send_pixel(corner_pixel(k));
      end

      // One column, two rows: every extreme lands on a luma-only and a chroma pixel
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 13'd1);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      for (int k = 0; k < 10; k++) begin
         send_pixel(corner_pixel(k));
         send_pixel(corner_pixel(k));
      end

      // Random frames; some geometries are changed while a row is still open
      run_frames(13'd16, 13'd4, 200);
      run_frames(13'd0, 13'd0, 30);
      run_frames(13'h1FFF, 13'd1, 60);
      run_frames(13'd32, 13'd3, 150);
      run_frames(13'd4096, 13'h1FFF, 40);
      run_frames(13'd16, 13'd1, 100);
      run_frames(13'd17, 13'd5, 200);
      run_frames(13'd1, 13'd4096, 100);
      run_frames(13'd48, 13'd2, 200);
      run_frames(13'd16, 13'd2, 170);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.expected_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: random stalls, and two long hold-offs while the sender bursts
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int unsigned gap;
         if (pixels_taken == 300 || pixels_taken == 900) begin
            rsp_tready <= 1'b0;
            burst_mode = 1;
            repeat (HOLD_OFF_LEN) @(negedge clock);
            burst_mode = 0;
         end
         gap = sink_idles ? $urandom_range(0, 11) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         pixels_taken++;
         if (pixels_taken % 50 == 0) begin
            sink_idles = ($urandom_range(0, 2) != 0);
         end
         @(negedge clock);
      end
   end

   // Monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         handshake_seen = 0;
         if (req_tvalid && req_tready) begin
            sb.note_pixel(req_tdata);
            handshake_seen = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
            handshake_seen = 1;
         end
         stall_cycles = handshake_seen ? 0 : stall_cycles + 1;
      end
   end

   // Abort when nothing moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
